>>> rtl/round_robin_quantum_scheduler_assert.svh
// ---------------------------------------------------------------------------
// round_robin_quantum_scheduler_assert
// assertion macros used by the scheduler datapath
// ---------------------------------------------------------------------------
`ifndef ROUND_ROBIN_QUANTUM_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_QUANTUM_SCHEDULER_ASSERT_SVH

// condition holds at every clock edge out of reset
`define RRQS_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define RRQS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/rrqs_pkg.sv
// ---------------------------------------------------------------------------
// rrqs_pkg
// types shared by the round-robin scheduler controller, datapath and top
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrqs_pkg;

   localparam int QUANTUM_W = 16;
   localparam int FIELD_W   = 16;
   localparam int INDEX_W   = 4;
   localparam int END_W     = 24;
   localparam int SUM_W     = 32;

   localparam logic MODE_LOAD     = 1'b0;
   localparam logic MODE_DISPATCH = 1'b1;

   typedef struct packed {
      logic               mode;
      logic [FIELD_W-1:0] arrival_time;
      logic [FIELD_W-1:0] burst_time;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] job_index;
      logic [END_W-1:0]   slice_end_time;
      logic               job_finished;
      logic               all_done;
      logic [SUM_W-1:0]   turnaround_sum;
      logic [SUM_W-1:0]   waiting_sum;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic start;
      logic scan_clear;
      logic scan_step;
      logic jump;
      logic admit;
      logic pop_rd;
      logic job_rd;
      logic exec_time;
      logic exec_sum;
      logic push_job;
      logic out_load;
      logic out_done;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_jump;
      logic scan_done;
      logic admit_ok;
      logic none_left;
      logic out_free;
   } sts_type;

endpackage

>>> rtl/rrqs_datapath.sv
// ---------------------------------------------------------------------------
// rrqs_datapath
// job tables, ready fifo, scan unit, clock and sums, result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrqs_datapath #(
   parameter int MAX_JOBS  = 16,
   parameter int TIME_BITS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rrqs_pkg::cmd_type                   cmd,
   output rrqs_pkg::sts_type                   sts,
   input  rrqs_pkg::req_type                   req_data,
   input  logic [rrqs_pkg::QUANTUM_W-1:0]      quantum,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rrqs_pkg::rsp_type                   rsp_data
);

   localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CNT_W = $clog2(MAX_JOBS + 1);
   localparam int FW    = rrqs_pkg::FIELD_W;
   localparam int SW    = rrqs_pkg::SUM_W;

   logic [FW-1:0]    arrival_mem   [MAX_JOBS];
   logic [FW-1:0]    burst_mem     [MAX_JOBS];
   logic [FW-1:0]    remaining_mem [MAX_JOBS];
   logic [IDX_W-1:0] fifo_mem      [MAX_JOBS];

   logic [MAX_JOBS-1:0]  admitted_ff, admitted_in;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]     fifo_count_ff, fifo_count_in;
   logic [CNT_W-1:0]     job_count_ff, job_count_in;
   logic [CNT_W-1:0]     unfinished_ff, unfinished_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic                 started_ff, started_in;
   logic [SW-1:0]        tat_sum_ff, tat_sum_in;
   logic [SW-1:0]        wait_sum_ff, wait_sum_in;

   logic [CNT_W-1:0] scan_idx_ff, scan_idx_in;
   logic             cmp_v_ff, cmp_v_in;
   logic [IDX_W-1:0] cmp_idx_ff;
   logic             best_v_ff, best_v_in;
   logic [FW-1:0]    best_arr_ff, best_arr_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;

   logic [IDX_W-1:0] fifo_q_ff;
   logic [IDX_W-1:0] job_ff;
   logic [FW-1:0]    arr_q_ff, burst_q_ff, rem_q_ff;
   logic             finished_ff, finished_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rrqs_pkg::rsp_type rsp_ff;

   logic [IDX_W-1:0]   rd_addr;
   logic [IDX_W-1:0]   load_addr;
   logic [CNT_W:0]     tail_sum;
   logic [IDX_W-1:0]   tail;
   logic [IDX_W-1:0]   push_val;
   logic               push_en;
   logic               load_ok;
   logic               scan_rd;
   logic [FW-1:0]      q_eff, run, rem_new;
   logic [TIME_BITS:0] time_sum;
   logic [SW-1:0]      tat;
   logic [FW-1:0]      load_burst;
   logic [31:0]        job_ext, time_ext;

   assign load_addr  = job_count_ff[IDX_W-1:0];
   assign load_ok    = cmd.load && !started_ff && (job_count_ff < CNT_W'(MAX_JOBS));
   assign load_burst = (req_data.burst_time == '0) ? FW'(1) : req_data.burst_time;
   assign scan_rd    = cmd.scan_step && (scan_idx_ff < job_count_ff);
   assign rd_addr    = cmd.job_rd ? fifo_q_ff : scan_idx_ff[IDX_W-1:0];

   // circular tail without a power-of-two depth
   assign tail_sum = (CNT_W+1)'(head_ff) + (CNT_W+1)'(fifo_count_ff);
   assign tail     = (tail_sum >= (CNT_W+1)'(MAX_JOBS)) ?
                     IDX_W'(tail_sum - (CNT_W+1)'(MAX_JOBS)) : IDX_W'(tail_sum);
   assign push_val = cmd.admit ? best_idx_ff : job_ff;
   assign push_en  = ((cmd.admit && sts.admit_ok) || (cmd.push_job && !finished_ff))
                     && (fifo_count_ff < CNT_W'(MAX_JOBS));

   assign q_eff    = (quantum == '0) ? FW'(1) : quantum;
   assign run      = (rem_q_ff < q_eff) ? rem_q_ff : q_eff;
   assign rem_new  = rem_q_ff - run;
   assign time_sum = (TIME_BITS+1)'(time_ff) + (TIME_BITS+1)'(run);
   assign tat      = SW'(time_ff) - SW'(arr_q_ff);
   assign job_ext  = 32'(job_ff);
   assign time_ext = 32'(time_ff);

   always_ff @(posedge clock) begin
      if (load_ok) begin
         arrival_mem[load_addr] <= req_data.arrival_time;
         burst_mem[load_addr]   <= load_burst;
      end
      if (load_ok) begin
         remaining_mem[load_addr] <= load_burst;
      end else if (cmd.exec_time) begin
         remaining_mem[job_ff] <= rem_new;
      end
      if (push_en) begin
         fifo_mem[tail] <= push_val;
      end
      if (scan_rd || cmd.job_rd) begin
         arr_q_ff <= arrival_mem[rd_addr];
      end
      if (cmd.job_rd) begin
         burst_q_ff <= burst_mem[rd_addr];
         rem_q_ff   <= remaining_mem[rd_addr];
         job_ff     <= fifo_q_ff;
      end
      if (cmd.pop_rd) begin
         fifo_q_ff <= fifo_mem[head_ff];
      end
      if (scan_rd) begin
         cmp_idx_ff <= scan_idx_ff[IDX_W-1:0];
      end
      if (cmd.out_load) begin
         rsp_ff.job_index      <= cmd.out_done ? '0 : job_ext[rrqs_pkg::INDEX_W-1:0];
         rsp_ff.slice_end_time <= time_ext[rrqs_pkg::END_W-1:0];
         rsp_ff.job_finished   <= cmd.out_done ? 1'b0 : finished_ff;
         rsp_ff.all_done       <= cmd.out_done;
         rsp_ff.turnaround_sum <= tat_sum_ff;
         rsp_ff.waiting_sum    <= wait_sum_ff;
      end
   end

   always_comb begin
      admitted_in   = admitted_ff;
      head_in       = head_ff;
      fifo_count_in = fifo_count_ff;
      job_count_in  = job_count_ff;
      unfinished_in = unfinished_ff;
      time_in       = time_ff;
      started_in    = started_ff;
      tat_sum_in    = tat_sum_ff;
      wait_sum_in   = wait_sum_ff;
      scan_idx_in   = scan_idx_ff;
      cmp_v_in      = 1'b0;
      best_v_in     = best_v_ff;
      best_arr_in   = best_arr_ff;
      best_idx_in   = best_idx_ff;
      finished_in   = finished_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (load_ok) begin
         job_count_in  = job_count_ff + 1'b1;
         unfinished_in = unfinished_ff + 1'b1;
      end
      if (cmd.start) begin
         started_in = 1'b1;
      end
      if (cmd.scan_clear) begin
         scan_idx_in = '0;
         best_v_in   = 1'b0;
      end
      if (scan_rd) begin
         scan_idx_in = scan_idx_ff + 1'b1;
         cmp_v_in    = !admitted_ff[scan_idx_ff[IDX_W-1:0]];
      end
      // strict compare keeps the lowest index on equal arrivals
      if (cmp_v_ff && (!best_v_ff || (arr_q_ff < best_arr_ff))) begin
         best_v_in   = 1'b1;
         best_arr_in = arr_q_ff;
         best_idx_in = cmp_idx_ff;
      end
      if (cmd.jump && best_v_ff && (TIME_BITS'(best_arr_ff) > time_ff)) begin
         time_in = TIME_BITS'(best_arr_ff);
      end
      if (cmd.admit && sts.admit_ok) begin
         admitted_in[best_idx_ff] = 1'b1;
      end
      if (cmd.pop_rd) begin
         head_in       = (head_ff == IDX_W'(MAX_JOBS - 1)) ? '0 : head_ff + 1'b1;
         fifo_count_in = fifo_count_ff - 1'b1;
      end
      if (push_en) begin
         fifo_count_in = fifo_count_ff + 1'b1;
      end
      if (cmd.exec_time) begin
         time_in     = time_sum[TIME_BITS] ? '1 : time_sum[TIME_BITS-1:0];
         finished_in = (rem_new == '0);
      end
      if (cmd.exec_sum && finished_ff) begin
         unfinished_in = unfinished_ff - 1'b1;
         tat_sum_in    = tat_sum_ff + tat;
         if (tat > SW'(burst_q_ff)) begin
            wait_sum_in = wait_sum_ff + (tat - SW'(burst_q_ff));
         end
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         admitted_ff   <= '0;
         head_ff       <= '0;
         fifo_count_ff <= '0;
         job_count_ff  <= '0;
         unfinished_ff <= '0;
         time_ff       <= '0;
         started_ff    <= 1'b0;
         tat_sum_ff    <= '0;
         wait_sum_ff   <= '0;
         scan_idx_ff   <= '0;
         cmp_v_ff      <= 1'b0;
         best_v_ff     <= 1'b0;
         finished_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         admitted_ff   <= admitted_in;
         head_ff       <= head_in;
         fifo_count_ff <= fifo_count_in;
         job_count_ff  <= job_count_in;
         unfinished_ff <= unfinished_in;
         time_ff       <= time_in;
         started_ff    <= started_in;
         tat_sum_ff    <= tat_sum_in;
         wait_sum_ff   <= wait_sum_in;
         scan_idx_ff   <= scan_idx_in;
         cmp_v_ff      <= cmp_v_in;
         best_v_ff     <= best_v_in;
         finished_ff   <= finished_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_arr_ff <= best_arr_in;
      best_idx_ff <= best_idx_in;
   end

   assign sts.need_jump = (unfinished_ff != '0) && (fifo_count_ff == '0);
   assign sts.scan_done = (scan_idx_ff >= job_count_ff) && !cmp_v_ff;
   assign sts.admit_ok  = best_v_ff && (TIME_BITS'(best_arr_ff) <= time_ff);
   assign sts.none_left = (unfinished_ff == '0) || (fifo_count_ff == '0);
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`include "round_robin_quantum_scheduler_assert.svh"

   `RRQS_ASSERT_ALWAYS(a_fifo_bound, fifo_count_ff <= CNT_W'(MAX_JOBS),
                       "fifo count overflow")
   `RRQS_ASSERT_ALWAYS(a_unfinished_bound, unfinished_ff <= job_count_ff,
                       "unfinished above loaded")
   `RRQS_ASSERT_NEXT(a_admit_marks, cmd.admit && sts.admit_ok,
                     admitted_ff[$past(best_idx_ff)], "admitted job not marked")
   `RRQS_ASSERT_NEXT(a_time_monotonic, 1'b1, time_ff >= $past(time_ff),
                     "clock moved backwards")

endmodule

>>> rtl/rrqs_controller.sv
// ---------------------------------------------------------------------------
// rrqs_controller
// sequences load, arrival scans, slice execution and result hand-off
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrqs_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_mode,
   input  rrqs_pkg::sts_type sts,
   output rrqs_pkg::cmd_type cmd
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_EMPTY  = 4'd1;
   localparam logic [3:0] ST_JSCAN  = 4'd2;
   localparam logic [3:0] ST_ACLR   = 4'd3;
   localparam logic [3:0] ST_ASCAN  = 4'd4;
   localparam logic [3:0] ST_CHECK  = 4'd5;
   localparam logic [3:0] ST_JRD    = 4'd6;
   localparam logic [3:0] ST_EXT    = 4'd7;
   localparam logic [3:0] ST_EXS    = 4'd8;
   localparam logic [3:0] ST_PUSH   = 4'd9;
   localparam logic [3:0] ST_OUT    = 4'd10;
   localparam logic [3:0] ST_JCLR   = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       post_ff, post_in;
   logic       done_ff, done_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      post_in  = post_ff;
      done_in  = done_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_mode == rrqs_pkg::MODE_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  post_in   = 1'b0;
                  state_in  = ST_EMPTY;
               end
            end
         end
         ST_EMPTY: begin
            state_in = sts.need_jump ? ST_JCLR : ST_CHECK;
         end
         ST_JCLR: begin
            cmd.scan_clear = 1'b1;
            state_in       = ST_JSCAN;
         end
         ST_JSCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               cmd.jump = 1'b1;
               state_in = ST_ACLR;
            end
         end
         ST_ACLR: begin
            cmd.scan_clear = 1'b1;
            state_in       = ST_ASCAN;
         end
         ST_ASCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               // one admission per scan, keeps arrival-then-index order
               if (sts.admit_ok) begin
                  cmd.admit = 1'b1;
                  state_in  = ST_ACLR;
               end else begin
                  state_in = post_ff ? ST_PUSH : ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (sts.none_left) begin
               done_in  = 1'b1;
               state_in = ST_OUT;
            end else begin
               cmd.pop_rd = 1'b1;
               state_in   = ST_JRD;
            end
         end
         ST_JRD: begin
            cmd.job_rd = 1'b1;
            state_in   = ST_EXT;
         end
         ST_EXT: begin
            cmd.exec_time = 1'b1;
            state_in      = ST_EXS;
         end
         ST_EXS: begin
            cmd.exec_sum = 1'b1;
            post_in      = 1'b1;
            state_in     = ST_ACLR;
         end
         ST_PUSH: begin
            cmd.push_job = 1'b1;
            done_in      = 1'b0;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_done = done_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         post_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         post_ff  <= post_in;
         done_ff  <= done_in;
      end
   end

endmodule

>>> rtl/round_robin_quantum_scheduler.sv
// ---------------------------------------------------------------------------
// round_robin_quantum_scheduler
// round-robin job scheduler with a programmable time quantum
// ---------------------------------------------------------------------------
// usage: a request with mode 0 loads one job (arrival, burst), unless the
// tables are full or dispatching has begun, and gives no response. a request
// with mode 1 runs one slice, or reports all done, and gives exactly one
// response: the job run, slice end time, finished flag, all-done flag and
// running turnaround and waiting sums. scans read the arrival table one
// entry per step through its single read port. an empty queue first gets a
// scan that moves the clock forward to the earliest waiting arrival, then
// admission scans, one admitted job per scan; a slice reads and runs one
// job, rescans for arrivals the same way, then requeues it if unfinished.
// one request is in work at a time; the next request is taken as soon as
// the response is placed in the output register, even while it waits.
// a stalled receiver holds the response and blocks only the next dispatch.
// reset clears all jobs, the queue, the clock and the sums, and sets the
// quantum to 4; tables need no clearing pass. the quantum register sits at
// byte address 0, must be written only while idle; the block does not check.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module round_robin_quantum_scheduler #(
   parameter int MAX_JOBS  = 16,
   parameter int TIME_BITS = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rrqs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rrqs_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam logic [2:0] ADDR_QUANTUM = 3'd0;

   logic [rrqs_pkg::QUANTUM_W-1:0] quantum_ff, quantum_in;
   rrqs_pkg::cmd_type cmd;
   rrqs_pkg::sts_type sts;

   assign pready = 1'b1;

   always_comb begin
      quantum_in = quantum_ff;
      if (psel && penable && pwrite && (paddr == ADDR_QUANTUM)) begin
         quantum_in = pwdata[rrqs_pkg::QUANTUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= rrqs_pkg::QUANTUM_W'(4);
      end else begin
         quantum_ff <= quantum_in;
      end
   end

   assign prdata = (paddr == ADDR_QUANTUM) ? 32'(quantum_ff) : '0;

   rrqs_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_data.mode),
      .sts       (sts),
      .cmd       (cmd)
   );

   rrqs_datapath #(
      .MAX_JOBS  (MAX_JOBS),
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .quantum   (quantum_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> bench/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the round-robin quantum scheduler
// ---------------------------------------------------------------------------
// loads one set of jobs, then runs dispatch phases under a series of quantum
// settings, the extremes included. an in-bench scheduler model predicts every
// slice, and each response is compared field by field with the oldest
// prediction. both channels idle and stall at random, with quiet stretches.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam int JOBS       = 16;
   localparam int TIME_LIMIT = (1 << 24) - 1;
   localparam int IDLE_LIMIT = 20000;
   localparam logic [2:0] QUANTUM_ADDR = 3'd0;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   rrqs_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rrqs_pkg::rsp_type rsp_data;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [2:0]        paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   round_robin_quantum_scheduler u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // scheduler model state
   logic [15:0]       quantum;
   int unsigned       arrival_of [JOBS];
   int unsigned       burst_of [JOBS];
   int unsigned       left_of [JOBS];
   logic [JOBS-1:0]   admitted;
   int unsigned       ready_jobs [$];
   int unsigned       loaded;
   int unsigned       unfinished;
   longint unsigned   now;
   bit                dispatching;
   logic [31:0]       turnaround_total;
   logic [31:0]       waiting_total;
   bit                all_finished;

   rrqs_pkg::rsp_type expected_slices [$];
   int          errors;
   bit          quiet;
   int          idle_cycles;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int unsigned earliest_waiting_job();
      int unsigned best;
      best = JOBS;
      for (int unsigned j = 0; j < loaded; j++) begin
         if (!admitted[j] && (best == JOBS || arrival_of[j] < arrival_of[best]))
            best = j;
      end
      return best;
   endfunction

   function automatic void admit_arrivals();
      int unsigned j;
      forever begin
         j = earliest_waiting_job();
         if (j >= JOBS || arrival_of[j] > now)
            return;
         admitted[j] = 1'b1;
         ready_jobs.push_back(j);
      end
   endfunction

   function automatic void predict_request(input rrqs_pkg::req_type item);
      rrqs_pkg::rsp_type slice;
      int unsigned j;
      int unsigned run;
      int unsigned q;
      int unsigned b;
      logic [31:0] tat;
      if (item.mode == rrqs_pkg::MODE_LOAD) begin
         if (dispatching || loaded >= JOBS)
            return;
         b = (item.burst_time == 0) ? 1 : item.burst_time;
         arrival_of[loaded] = item.arrival_time;
         burst_of[loaded]   = b;
         left_of[loaded]    = b;
         loaded++;
         unfinished++;
         return;
      end
      dispatching = 1'b1;
      slice = '0;
      if (unfinished != 0 && ready_jobs.size() == 0) begin
         j = earliest_waiting_job();
         if (j < JOBS && arrival_of[j] > now)
            now = arrival_of[j];
         admit_arrivals();
      end
      if (unfinished == 0 || ready_jobs.size() == 0) begin
         slice.slice_end_time = now[rrqs_pkg::END_W-1:0];
         slice.all_done       = 1'b1;
         slice.turnaround_sum = turnaround_total;
         slice.waiting_sum    = waiting_total;
         all_finished         = 1'b1;
         expected_slices.push_back(slice);
         return;
      end
      j   = ready_jobs.pop_front();
      q   = (quantum == 0) ? 1 : quantum;
      run = (left_of[j] < q) ? left_of[j] : q;
      now = now + run;
      if (now > TIME_LIMIT)
         now = TIME_LIMIT;
      left_of[j] -= run;
      if (left_of[j] == 0) begin
         tat = 32'(now - arrival_of[j]);
         slice.job_finished = 1'b1;
         unfinished--;
         turnaround_total += tat;
         if (tat > burst_of[j])
            waiting_total += tat - burst_of[j];
      end
      admit_arrivals();
      if (!slice.job_finished)
         ready_jobs.push_back(j);
      slice.job_index      = j[rrqs_pkg::INDEX_W-1:0];
      slice.slice_end_time = now[rrqs_pkg::END_W-1:0];
      slice.turnaround_sum = turnaround_total;
      slice.waiting_sum    = waiting_total;
      expected_slices.push_back(slice);
   endfunction

   function automatic void report_mismatch(input string what, input longint want,
                                           input longint got);
      errors++;
      if (errors <= 10)
         $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
   endfunction

   task automatic send_request(input rrqs_pkg::req_type item);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_request(item);
   endtask

   task automatic stop_requests();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_for_slices();
      while (expected_slices.size() != 0) @(posedge clock);
   endtask

   // write the quantum while idle, then read it back
   task automatic write_quantum(input logic [15:0] value);
      stop_requests();
      wait_for_slices();
      repeat (20) @(negedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      paddr   <= QUANTUM_ADDR;
      pwdata  <= {16'($urandom_range(0, 65535)), value};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      quantum = value;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[15:0] !== quantum)
         report_mismatch("quantum readback", quantum, prdata[15:0]);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic send_dispatch();
      rrqs_pkg::req_type item;
      item.mode         = rrqs_pkg::MODE_DISPATCH;
      item.arrival_time = $urandom_range(0, 65535);
      item.burst_time   = $urandom_range(0, 65535);
      send_request(item);
   endtask

   task automatic send_load(input int unsigned arrival, input int unsigned burst);
      rrqs_pkg::req_type item;
      item.mode         = rrqs_pkg::MODE_LOAD;
      item.arrival_time = arrival[rrqs_pkg::FIELD_W-1:0];
      item.burst_time   = burst[rrqs_pkg::FIELD_W-1:0];
      send_request(item);
   endtask

   // ties at one arrival tick, zero and full bursts, late arrival, then loads
   // past capacity which must be dropped
   task automatic test_job_loading();
      send_load(100, 0);
      send_load(100, 65535);
      send_load(65535, 65535);
      send_load(300, 1);
      for (int i = 4; i < JOBS; i++) begin
         if (i % 2 == 0)
            send_load($urandom_range(100, 40000), $urandom_range(1, 200));
         else
            send_load($urandom_range(100, 40000), $urandom_range(20000, 65535));
      end
      send_load(0, 0);
      send_load(65535, 65535);
      for (int i = 0; i < 6; i++)
         send_load($urandom_range(0, 65535), $urandom_range(0, 65535));
   endtask

   // first slice jumps the clock to the earliest arrival under the reset quantum
   task automatic test_reset_quantum(input int count);
      for (int i = 0; i < count; i++)
         send_dispatch();
   endtask

   task automatic test_quantum_phase(input logic [15:0] value, input int count,
                                     input bit calm);
      write_quantum(value);
      quiet = calm;
      for (int i = 0; i < count; i++)
         send_dispatch();
      quiet = 1'b0;
   endtask

   // full quantum finishes every job; then dispatches report all done
   task automatic test_drain();
      write_quantum(16'hffff);
      while (!all_finished)
         send_dispatch();
      for (int i = 0; i < 5; i++)
         send_dispatch();
   endtask

   // receiver side, with its own random stalls
   initial begin
      int gap;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         gap = quiet ? 0 : $urandom_range(0, 13);
         if (gap > 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      rrqs_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_slices.size() == 0) begin
            report_mismatch("unexpected response, job", -1, rsp_data.job_index);
         end else begin
            want = expected_slices.pop_front();
            if (rsp_data.job_index !== want.job_index)
               report_mismatch("job_index", want.job_index, rsp_data.job_index);
            if (rsp_data.slice_end_time !== want.slice_end_time)
               report_mismatch("slice_end_time", want.slice_end_time,
                               rsp_data.slice_end_time);
            if (rsp_data.job_finished !== want.job_finished)
               report_mismatch("job_finished", want.job_finished, rsp_data.job_finished);
            if (rsp_data.all_done !== want.all_done)
               report_mismatch("all_done", want.all_done, rsp_data.all_done);
            if (rsp_data.turnaround_sum !== want.turnaround_sum)
               report_mismatch("turnaround_sum", want.turnaround_sum,
                               rsp_data.turnaround_sum);
            if (rsp_data.waiting_sum !== want.waiting_sum)
               report_mismatch("waiting_sum", want.waiting_sum, rsp_data.waiting_sum);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      idle_cycles = 0;
      errors      = 0;
      quiet       = 1'b0;
      quantum          = 16'd4;
      admitted         = '0;
      loaded           = 0;
      unfinished       = 0;
      now              = 0;
      dispatching      = 1'b0;
      turnaround_total = '0;
      waiting_total    = '0;
      all_finished     = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_job_loading();
      test_reset_quantum(150);
      test_quantum_phase(16'd1, 150, 1'b0);
      test_quantum_phase(16'd0, 150, 1'b1);
      for (int p = 0; p < 9; p++)
         test_quantum_phase($urandom_range(2, 300), 150, (p % 3) == 2);
      test_drain();

      stop_requests();
      wait_for_slices();
      repeat (400) @(posedge clock);
      if (errors == 0 && expected_slices.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
